// ===== hdl/greedy_row_range_coalescer_defines.svh =====
// Assertion macros used by the top-level coalescer RTL file.
`ifndef GREEDY_ROW_RANGE_COALESCER_DEFINES_SVH
`define GREEDY_ROW_RANGE_COALESCER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define GRRC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled during reset.
`define GRRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GRRC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define GRRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/grrc_pkg.sv =====
package grrc_pkg;

	localparam int ROW_INDEX_BITS_DEF = 48;
	localparam int TARGET_BITS        = 40;
	localparam logic [TARGET_BITS-1:0] TARGET_RESET = 40'd100000;
	localparam int MAX_RESULTS        = 3;

	// Result count per transaction, 0 to MAX_RESULTS.
	typedef logic [1:0] res_cnt_t;

	typedef struct packed {
		logic cur_valid;
		logic held_valid;
	} grrc_flags_t;

endpackage

// ===== hdl/grrc_if.sv =====
interface grrc_in_if #(
	parameter int W = 48
);
	logic         valid;
	logic         ready;
	logic [W-1:0] range_begin;
	logic [W-1:0] range_end;
	logic         final_range;

	modport source (output valid, range_begin, range_end, final_range, input ready);
	modport sink   (input valid, range_begin, range_end, final_range, output ready);
endinterface

interface grrc_out_if #(
	parameter int W = 48
);
	logic         valid;
	logic         ready;
	logic [W-1:0] out_begin;
	logic [W-1:0] out_end;
	logic         out_last;

	modport source (output valid, out_begin, out_end, out_last, input ready);
	modport sink   (input valid, out_begin, out_end, out_last, output ready);
endinterface

// ===== hdl/grrc_step.sv =====
module grrc_step #(
	parameter int W = grrc_pkg::ROW_INDEX_BITS_DEF
) (
	input  logic [W-1:0]                         cur_beg,
	input  logic [W-1:0]                         cur_end,
	input  logic [W-1:0]                         held_beg,
	input  logic [W-1:0]                         held_end,
	input  grrc_pkg::grrc_flags_t                flags,
	input  logic [W-1:0]                         in_beg,
	input  logic [W-1:0]                         in_end,
	input  logic [W-1:0]                         in_len,
	input  logic                                 in_fin,
	input  logic [grrc_pkg::TARGET_BITS-1:0]     target,
	output logic [W-1:0]                         nxt_cur_beg,
	output logic [W-1:0]                         nxt_cur_end,
	output logic [W-1:0]                         nxt_held_beg,
	output logic [W-1:0]                         nxt_held_end,
	output grrc_pkg::grrc_flags_t                nxt_flags,
	output logic [W-1:0]                         res_beg  [grrc_pkg::MAX_RESULTS],
	output logic [W-1:0]                         res_end  [grrc_pkg::MAX_RESULTS],
	output logic                                 res_last [grrc_pkg::MAX_RESULTS],
	output grrc_pkg::res_cnt_t                   n_res
);
	import grrc_pkg::*;

	// Compare width: holds 3*x+3 for a row count and 2*target.
	localparam int CW = (W + 3 > TARGET_BITS + 2) ? W + 3 : TARGET_BITS + 2;

	// x below max(floor(2T/3), 1), without a divider: x < floor(2T/3) iff 3x+3 <= 2T.
	function automatic logic below_min(input logic [W-1:0] x, input logic [CW-1:0] t2);
		logic [CW-1:0] x3;
		x3 = (CW'(x) << 1) + CW'(x) + CW'(3);
		return (x == '0) || (x3 <= t2);
	endfunction

	logic [CW-1:0] t1, t2;
	logic [W-1:0]  cur_len, ext_len, new_len;
	logic          absorb, close, fresh, hv;
	logic [CW-1:0] sum1, sum2;

	assign t1 = CW'(target);
	assign t2 = CW'(target) << 1;

	assign cur_len = (cur_end >= cur_beg) ? cur_end - cur_beg : '0;
	assign ext_len = (in_end >= cur_beg) ? in_end - cur_beg : '0;

	assign sum1 = CW'(cur_len) + CW'(in_len);
	assign sum2 = (CW'(cur_len) << 1) + CW'(in_len);

	assign absorb = below_min(cur_len, t2) || (sum1 <= t1) || (sum2 < t2);
	assign close  = flags.cur_valid && !absorb;
	assign fresh  = !flags.cur_valid || close;

	assign new_len = fresh ? in_len : ext_len;
	assign hv      = flags.held_valid || close;

	always_comb begin
		logic [W-1:0] nb, hb, he;
		res_cnt_t     k;
		nb = fresh ? in_beg : cur_beg;
		hb = close ? cur_beg : held_beg;
		he = close ? cur_end : held_end;
		k  = '0;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			res_beg[i]  = '0;
			res_end[i]  = '0;
			res_last[i] = 1'b0;
		end

		// Closing pushes out the range held from before.
		if (close && flags.held_valid) begin
			res_beg[k]  = held_beg;
			res_end[k]  = held_end;
			res_last[k] = 1'b0;
			k = k + res_cnt_t'(1);
		end

		if (in_fin) begin
			if (!below_min(new_len, t2) || !hv) begin
				if (hv) begin
					res_beg[k]  = hb;
					res_end[k]  = he;
					res_last[k] = 1'b0;
					k = k + res_cnt_t'(1);
				end
				res_beg[k]  = nb;
				res_end[k]  = in_end;
				res_last[k] = 1'b1;
				k = k + res_cnt_t'(1);
			end else begin
				// Fold a short tail into the held range.
				res_beg[k]  = hb;
				res_end[k]  = in_end;
				res_last[k] = 1'b1;
				k = k + res_cnt_t'(1);
			end
		end
		n_res = k;

		if (in_fin) begin
			nxt_cur_beg  = '0;
			nxt_cur_end  = '0;
			nxt_held_beg = '0;
			nxt_held_end = '0;
			nxt_flags    = '0;
		end else begin
			nxt_cur_beg          = nb;
			nxt_cur_end          = in_end;
			nxt_held_beg         = hb;
			nxt_held_end         = he;
			nxt_flags.cur_valid  = 1'b1;
			nxt_flags.held_valid = hv;
		end
	end

endmodule

// ===== hdl/greedy_row_range_coalescer.sv =====
// Greedy row range coalescer: takes one input range per cycle while it is not stalled and
// produces merged ranges one per cycle, while the output is taken, through a three-entry
// result buffer. The first result of an input range is presented once the range has passed
// the input register and then the result buffer. A range that closes the current merge yields
// at most one result, a final range up to three; the input is taken again once the buffer
// holds at most one entry that leaves in that cycle. The target row count (target_q) is
// written through wr_en/wr_data and applies from the next cycle on, to any range that has
// not yet left the input register.
module greedy_row_range_coalescer #(
	parameter int ROW_INDEX_BITS = grrc_pkg::ROW_INDEX_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [grrc_pkg::TARGET_BITS-1:0]  wr_data,
	grrc_in_if.sink                           ranges,
	grrc_out_if.source                        merged
);
	import grrc_pkg::*;
	`include "greedy_row_range_coalescer_defines.svh"

	localparam int W = ROW_INDEX_BITS;

	logic [TARGET_BITS-1:0] target_q;

	logic         vld_s1;
	logic [W-1:0] beg_s1, rend_s1, len_s1;
	logic         fin_s1;

	logic [W-1:0] cur_beg_q, cur_end_q, held_beg_q, held_end_q;
	grrc_flags_t  flags_q;

	logic [W-1:0] slot_beg_q  [MAX_RESULTS];
	logic [W-1:0] slot_end_q  [MAX_RESULTS];
	logic         slot_last_q [MAX_RESULTS];
	res_cnt_t     cnt_q;

	logic [W-1:0] nxt_cur_beg, nxt_cur_end, nxt_held_beg, nxt_held_end;
	grrc_flags_t  nxt_flags;
	logic [W-1:0] res_beg  [MAX_RESULTS];
	logic [W-1:0] res_end  [MAX_RESULTS];
	logic         res_last [MAX_RESULTS];
	res_cnt_t     n_res;

	logic pop, adv, take;

	assign pop  = merged.valid && merged.ready;
	// Advance only into an empty buffer, counting the entry that leaves now.
	assign adv  = vld_s1 && ((cnt_q == '0) || (cnt_q == res_cnt_t'(1) && pop));
	assign take = ranges.valid && ranges.ready;

	assign ranges.ready = !vld_s1 || adv;

	assign merged.valid     = (cnt_q != '0);
	assign merged.out_begin = slot_beg_q[0];
	assign merged.out_end   = slot_end_q[0];
	assign merged.out_last  = slot_last_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
		end else if (wr_en) begin
			target_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			beg_s1  <= ranges.range_begin;
			rend_s1 <= ranges.range_end;
			fin_s1  <= ranges.final_range;
			len_s1  <= (ranges.range_end >= ranges.range_begin) ?
				ranges.range_end - ranges.range_begin : '0;
		end
	end

	grrc_step #(
		.W (W)
	) u_step (
		.cur_beg      (cur_beg_q),
		.cur_end      (cur_end_q),
		.held_beg     (held_beg_q),
		.held_end     (held_end_q),
		.flags        (flags_q),
		.in_beg       (beg_s1),
		.in_end       (rend_s1),
		.in_len       (len_s1),
		.in_fin       (fin_s1),
		.target       (target_q),
		.nxt_cur_beg  (nxt_cur_beg),
		.nxt_cur_end  (nxt_cur_end),
		.nxt_held_beg (nxt_held_beg),
		.nxt_held_end (nxt_held_end),
		.nxt_flags    (nxt_flags),
		.res_beg      (res_beg),
		.res_end      (res_end),
		.res_last     (res_last),
		.n_res        (n_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_beg_q  <= '0;
			cur_end_q  <= '0;
			held_beg_q <= '0;
			held_end_q <= '0;
			flags_q    <= '0;
		end else if (adv) begin
			cur_beg_q  <= nxt_cur_beg;
			cur_end_q  <= nxt_cur_end;
			held_beg_q <= nxt_held_beg;
			held_end_q <= nxt_held_end;
			flags_q    <= nxt_flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (adv) begin
			cnt_q <= n_res;
		end else if (pop) begin
			cnt_q <= cnt_q - res_cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				slot_beg_q[i]  <= res_beg[i];
				slot_end_q[i]  <= res_end[i];
				slot_last_q[i] <= res_last[i];
			end
		end else if (pop) begin
			// Shift the buffer down by one.
			for (int i = 0; i < MAX_RESULTS - 1; i++) begin
				slot_beg_q[i]  <= slot_beg_q[i+1];
				slot_end_q[i]  <= slot_end_q[i+1];
				slot_last_q[i] <= slot_last_q[i+1];
			end
		end
	end

	`GRRC_ASSERT_IMPL(a_adv_room, clk, arst_n, adv,
		(cnt_q == '0) || (cnt_q == res_cnt_t'(1) && pop),
		"range advanced into a buffer that still holds results")
	`GRRC_ASSERT_NEXT(a_fin_clears, clk, arst_n, adv && fin_s1,
		!flags_q.cur_valid && !flags_q.held_valid,
		"merge state not cleared after the final range")
	`GRRC_ASSERT_IMPL(a_fin_emits, clk, arst_n, adv && fin_s1,
		n_res != '0,
		"final range produced no result")
	`GRRC_ASSERT_IMPL(a_held_has_cur, clk, arst_n, flags_q.held_valid,
		flags_q.cur_valid,
		"held range present without a current range")

endmodule
